FILE: hw/rtl/sirs_pkg.sv
package sirs_pkg;

  localparam int NUM_RULES  = 4;
  localparam int REG_COUNT  = 4;
  localparam int RIDX_W     = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
  localparam int RCNT_W     = $clog2(NUM_RULES + 1);
  localparam int TIME_W     = 32;
  localparam int PRIO_W     = 8;
  localparam int CMD_W      = 2;
  localparam int RULE_IDX_W = 3;
  localparam int CHOSEN_W   = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 42;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACTIVITY  = 2'd0,
    CMD_FIRST_KEY = 2'd1,
    CMD_SELECT    = 2'd2,
    CMD_COMPLETE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIO,
    ST_SCAN,
    ST_DONE
  } sirs_state_t;

  // same layout as the register: interval low, regardless-of-activity on top
  typedef struct packed {
    logic              regardless;
    logic              first_key;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] interval;
  } rule_cfg_t;

  typedef struct packed {
    logic              armed;
    logic              act;
    logic [TIME_W-1:0] sat;
  } rule_state_t;

  typedef struct packed {
    logic              rd_en;
    logic [RIDX_W-1:0] rd_addr;
    logic              wr_en;
    logic [RIDX_W-1:0] wr_addr;
  } mem_ctl_t;

endpackage

FILE: hw/rtl/sirs_rule_mem.sv
module sirs_rule_mem (
  input  logic                   clk,
  input  logic                   rst,
  input  sirs_pkg::mem_ctl_t     ctl,
  input  sirs_pkg::rule_state_t  wr_data,
  output sirs_pkg::rule_state_t  rd_data
);

  sirs_pkg::rule_state_t mem [sirs_pkg::NUM_RULES];
  sirs_pkg::rule_state_t rd_q;
  logic [sirs_pkg::NUM_RULES-1:0] vld;
  logic rd_vld;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_q   <= mem[ctl.rd_addr];
      rd_vld <= vld[ctl.rd_addr];
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.wr_en) begin
      vld[ctl.wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

FILE: hw/rtl/sirs_cfg_regs.sv
module sirs_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [sirs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sirs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [sirs_pkg::RIDX_W-1:0]         rd_addr,
  output sirs_pkg::rule_cfg_t                 rd_cfg
);

  sirs_pkg::rule_cfg_t cfg_q [sirs_pkg::NUM_RULES];
  logic idx_ok;

  assign idx_ok = (cfg_index < sirs_pkg::CFG_IDX_W'(sirs_pkg::REG_COUNT)) &&
                  (cfg_index < sirs_pkg::CFG_IDX_W'(sirs_pkg::NUM_RULES));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sirs_pkg::NUM_RULES; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (cfg_wr_en && idx_ok) begin
      cfg_q[cfg_index[sirs_pkg::RIDX_W-1:0]] <= sirs_pkg::rule_cfg_t'(cfg_data);
    end
  end

  assign rd_cfg = cfg_q[rd_addr];

endmodule

FILE: hw/rtl/station_id_rule_scheduler.sv
// Station identification rule scheduler. Every request on the s_ side carries one
// command (activity, first key, select, complete) and yields exactly one result on
// the m_ side; found travels in m_tuser and is 0 for every command but a successful
// select. A request is taken only while the block is idle. Its result is loaded after
// the states ST_PRIO, ST_SCAN and ST_DONE in that order: ST_PRIO fetches the priority
// of the named rule, then ST_SCAN walks the per-rule state memory one rule a cycle
// through its registered read port (the read of the next rule overlaps the write-back
// of the current one), and ST_DONE loads the result register. The block returns to
// idle with that load, so it takes no new request before the last one's result is
// loaded. The result register may still be waiting on m_tready while the next request
// is accepted; the load of the next result stalls until it is taken. Per-entry valid
// bits make the state read as zero after reset, so no clearing pass is needed. Rule
// registers are written through cfg_wr_en / cfg_index / cfg_data, by the user only
// while idle, which the block does not enforce; out-of-range indexes are ignored.
module station_id_rule_scheduler (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [sirs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sirs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // cmd[1:0], time_ms[33:2], rx_busy[34], fdx_allowed[35],
  // rule_index[38:36], zero[39]
  input  logic [sirs_pkg::S_TDATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // chosen_rule[2:0], zero[7:3]
  output logic [sirs_pkg::M_TDATA_W-1:0]    m_tdata,
  // found[0]
  output logic                              m_tuser
);

  sirs_pkg::sirs_state_t state, state_next;

  sirs_pkg::cmd_t                      cmd_q;
  logic [sirs_pkg::TIME_W-1:0]         time_q;
  logic                                rx_q;
  logic                                fdx_q;
  logic [sirs_pkg::RULE_IDX_W-1:0]     idx_q;

  logic [sirs_pkg::RCNT_W-1:0]         ic, ic_next;
  logic                                dv, dv_next;
  logic [sirs_pkg::RIDX_W-1:0]         di, di_next;
  logic                                have, have_next;
  logic [sirs_pkg::RIDX_W-1:0]         best, best_next;
  logic [sirs_pkg::PRIO_W-1:0]         best_prio, best_prio_next;
  logic [sirs_pkg::PRIO_W-1:0]         p_sel, p_sel_next;

  sirs_pkg::mem_ctl_t                  mem_ctl;
  sirs_pkg::rule_state_t               mem_rd, mem_wr;
  sirs_pkg::rule_cfg_t                 cfg_rd;
  logic [sirs_pkg::RIDX_W-1:0]         cfg_addr;

  logic accept, out_load, sel_ok, sel_allow, last_issued, due;

  assign s_tready    = (state == sirs_pkg::ST_IDLE);
  assign accept      = s_tvalid && s_tready;
  assign sel_ok      = ({1'b0, idx_q} < 4'(sirs_pkg::NUM_RULES));
  assign sel_allow   = !(rx_q && !fdx_q);
  assign last_issued = (ic == sirs_pkg::RCNT_W'(sirs_pkg::NUM_RULES));

  sirs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rd_addr   (cfg_addr),
    .rd_cfg    (cfg_rd)
  );

  sirs_rule_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mem_ctl),
    .wr_data (mem_wr),
    .rd_data (mem_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sirs_pkg::ST_IDLE;
      dv    <= 1'b0;
      have  <= 1'b0;
    end else begin
      state <= state_next;
      dv    <= dv_next;
      have  <= have_next;
    end
  end

  always_ff @(posedge clk) begin
    ic        <= ic_next;
    di        <= di_next;
    best      <= best_next;
    best_prio <= best_prio_next;
    p_sel     <= p_sel_next;
    if (accept) begin
      cmd_q  <= sirs_pkg::cmd_t'(s_tdata[1:0]);
      time_q <= s_tdata[33:2];
      rx_q   <= s_tdata[34];
      fdx_q  <= s_tdata[35];
      idx_q  <= s_tdata[38:36];
    end
  end

  always_comb begin
    state_next     = state;
    ic_next        = ic;
    dv_next        = 1'b0;
    di_next        = di;
    have_next      = have;
    best_next      = best;
    best_prio_next = best_prio;
    p_sel_next     = p_sel;
    cfg_addr       = di;
    mem_ctl        = '0;
    mem_ctl.rd_addr = ic[sirs_pkg::RIDX_W-1:0];
    mem_ctl.wr_addr = di;
    mem_wr         = mem_rd;
    out_load       = 1'b0;
    due            = 1'b0;

    unique case (state)
      sirs_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = sirs_pkg::ST_PRIO;
        end
      end
      sirs_pkg::ST_PRIO: begin
        // priority of the named rule, only meaningful for complete
        cfg_addr       = idx_q[sirs_pkg::RIDX_W-1:0];
        p_sel_next     = cfg_rd.prio;
        ic_next        = '0;
        have_next      = 1'b0;
        best_next      = '0;
        best_prio_next = '0;
        state_next     = sirs_pkg::ST_SCAN;
      end
      sirs_pkg::ST_SCAN: begin
        if (!last_issued) begin
          mem_ctl.rd_en = 1'b1;
          ic_next       = ic + 1'b1;
          dv_next       = 1'b1;
          di_next       = ic[sirs_pkg::RIDX_W-1:0];
        end else begin
          state_next = sirs_pkg::ST_DONE;
        end
        if (dv) begin
          case (cmd_q)
            sirs_pkg::CMD_ACTIVITY: begin
              mem_wr.act    = 1'b1;
              mem_ctl.wr_en = 1'b1;
            end
            sirs_pkg::CMD_FIRST_KEY: begin
              if (cfg_rd.first_key && (time_q >= cfg_rd.interval)) begin
                mem_wr.armed = 1'b1;
              end
              mem_ctl.wr_en = 1'b1;
            end
            sirs_pkg::CMD_SELECT: begin
              if (cfg_rd.first_key) begin
                due = mem_rd.armed;
              end else begin
                due = ((time_q - mem_rd.sat) >= cfg_rd.interval) &&
                      (cfg_rd.regardless || mem_rd.act);
              end
              // strict compare keeps the lowest index on equal priority
              if (sel_allow && due && (!have || (cfg_rd.prio > best_prio))) begin
                have_next      = 1'b1;
                best_next      = di;
                best_prio_next = cfg_rd.prio;
              end
            end
            sirs_pkg::CMD_COMPLETE: begin
              if (sel_ok && ((di == idx_q[sirs_pkg::RIDX_W-1:0]) ||
                             (cfg_rd.prio < p_sel))) begin
                mem_wr.armed  = 1'b0;
                mem_wr.act    = 1'b0;
                mem_wr.sat    = time_q;
                mem_ctl.wr_en = 1'b1;
              end
            end
          endcase
        end
      end
      sirs_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = sirs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sirs_pkg::ST_IDLE;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= have;
      m_tdata <= sirs_pkg::M_TDATA_W'(sirs_pkg::CHOSEN_W'(best));
    end
  end

endmodule

FILE: dv/station_id_rule_scheduler_chk.sv
module station_id_rule_scheduler_chk (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [sirs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sirs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  // cmd[1:0], time_ms[33:2], rx_busy[34], fdx_allowed[35],
  // rule_index[38:36], zero[39]
  input  logic [sirs_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // chosen_rule[2:0], zero[7:3]
  input  logic [sirs_pkg::M_TDATA_W-1:0]  m_tdata,
  // found[0]
  input  logic                            m_tuser,
  output int                              errors,
  output int                              outstanding,
  output int                              results_seen,
  output int                              hits
);
  timeunit 1ns;
  timeprecision 1ps;

  import sirs_pkg::*;

  typedef struct packed {
    logic                found;
    logic [CHOSEN_W-1:0] rule;
  } pick_t;

  pick_t             pick_q[$];
  rule_cfg_t         rules    [NUM_RULES];
  logic [TIME_W-1:0] sat_ms   [NUM_RULES];
  logic              act_seen [NUM_RULES];
  logic              armed    [NUM_RULES];

  // applies one command to the rule table and returns the pick it reports
  function automatic pick_t run_command(cmd_t cmd, logic [TIME_W-1:0] t_ms, logic rx,
                                        logic fdx, logic [RULE_IDX_W-1:0] idx);
    pick_t             res;
    logic              have;
    int                best;
    logic              due;
    logic [PRIO_W-1:0] p;
    res  = '0;
    have = 1'b0;
    best = 0;
    case (cmd)
      CMD_ACTIVITY: begin
        for (int i = 0; i < NUM_RULES; i++) act_seen[i] = 1'b1;
      end
      CMD_FIRST_KEY: begin
        for (int i = 0; i < NUM_RULES; i++)
          if (rules[i].first_key && t_ms >= rules[i].interval) armed[i] = 1'b1;
      end
      CMD_SELECT: begin
        // half duplex and receiving: nothing may be sent
        if (!(rx && !fdx)) begin
          for (int i = 0; i < NUM_RULES; i++) begin
            if (rules[i].first_key)
              due = armed[i];
            else
              due = (TIME_W'(t_ms - sat_ms[i]) >= rules[i].interval) &&
                    (rules[i].regardless || act_seen[i]);
            // strict compare keeps the lowest index on equal priority
            if (due && (!have || rules[i].prio > rules[best].prio)) begin
              have = 1'b1;
              best = i;
            end
          end
          if (have) begin
            res.found = 1'b1;
            res.rule  = CHOSEN_W'(best);
          end
        end
      end
      CMD_COMPLETE: begin
        if (idx < NUM_RULES) begin
          p = rules[idx].prio;
          for (int i = 0; i < NUM_RULES; i++) begin
            if (i == idx || rules[i].prio < p) begin
              sat_ms[i]   = t_ms;
              act_seen[i] = 1'b0;
              armed[i]    = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    pick_t got;
    pick_t want;
    if (rst) begin
      for (int i = 0; i < NUM_RULES; i++) begin
        rules[i]    = '0;
        sat_ms[i]   = '0;
        act_seen[i] = 1'b0;
        armed[i]    = 1'b0;
      end
      pick_q.delete();
      errors       = 0;
      outstanding  = 0;
      results_seen = 0;
      hits         = 0;
    end else begin
      if (cfg_wr_en && cfg_index < REG_COUNT && cfg_index < NUM_RULES)
        rules[cfg_index] = rule_cfg_t'(cfg_data);
      if (m_tvalid && m_tready) begin
        got.found = m_tuser;
        got.rule  = m_tdata[CHOSEN_W-1:0];
        results_seen++;
        if (got.found) hits++;
        if (pick_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result found=%0d rule=%0d", $time, got.found, got.rule);
        end else begin
          want = pick_q.pop_front();
          if (got.found !== want.found) begin
            errors++;
            $display("%0t: found mismatch, expected %0d, actual %0d",
                     $time, want.found, got.found);
          end
          if (got.rule !== want.rule) begin
            errors++;
            $display("%0t: chosen_rule mismatch, expected %0d, actual %0d",
                     $time, want.rule, got.rule);
          end
        end
      end
      if (s_tvalid && s_tready)
        pick_q.push_back(run_command(cmd_t'(s_tdata[1:0]), s_tdata[33:2], s_tdata[34],
                                     s_tdata[35], s_tdata[38:36]));
      outstanding = pick_q.size();
    end
  end

endmodule

FILE: dv/station_id_rule_scheduler_tb.sv
module station_id_rule_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sirs_pkg::*;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 240;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 12;
  localparam logic [CFG_IDX_W-1:0] REG_RULE0 = '0;
  localparam logic [CFG_IDX_W-1:0] REG_LAST  = '1;

  typedef struct packed {
    logic [RULE_IDX_W-1:0] rule_index;
    logic                  fdx;
    logic                  rx;
    logic [TIME_W-1:0]     t_ms;
    cmd_t                  cmd;
  } req_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic [S_TDATA_W-1:0]  s_tdata   = '0;
  logic                  m_tready  = 1'b0;
  logic                  s_tready;
  logic                  m_tvalid;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  m_tuser;

  int                send_idle = 0;
  int                stall_pct = 0;
  logic              hold_on   = 1'b0;
  event              holdoff_go;
  logic [TIME_W-1:0] now_ms    = '0;
  int                errors;
  int                outstanding;
  int                results_seen;
  int                hits;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  station_id_rule_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  station_id_rule_scheduler_chk chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .errors       (errors),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .hits         (hits)
  );

  always @(negedge clk) begin
    m_tready <= hold_on ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  // long receiver hold-off, counted here so the sender keeps pushing
  initial begin
    forever begin
      @(holdoff_go);
      @(posedge clk);
      hold_on = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_on = 1'b0;
    end
  end

  initial begin
    #5_000_000;
    $display("station_id_rule_scheduler_tb NOT OK");
    $finish;
  end

  function automatic logic [CFG_DATA_W-1:0] rule_word(logic [TIME_W-1:0] interval,
                                                      logic [PRIO_W-1:0] prio,
                                                      logic fk, logic regardless);
    rule_cfg_t r;
    r.interval   = interval;
    r.prio       = prio;
    r.first_key  = fk;
    r.regardless = regardless;
    return r;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_rule();
    logic [TIME_W-1:0] interval;
    logic [PRIO_W-1:0] prio;
    case ($urandom_range(9))
      0:       interval = '0;
      1:       interval = '1;
      2, 3:    interval = $urandom;
      default: interval = $urandom_range(2000);
    endcase
    case ($urandom_range(7))
      0:       prio = '1;
      1:       prio = PRIO_W'($urandom);
      default: prio = PRIO_W'($urandom_range(3));
    endcase
    return rule_word(interval, prio, $urandom_range(3) == 0, 1'($urandom_range(1)));
  endfunction

  function automatic req_t mk(cmd_t cmd, logic [TIME_W-1:0] t_ms, logic rx, logic fdx,
                              logic [RULE_IDX_W-1:0] idx);
    req_t r;
    r.cmd        = cmd;
    r.t_ms       = t_ms;
    r.rx         = rx;
    r.fdx        = fdx;
    r.rule_index = idx;
    return r;
  endfunction

  // mostly a clock that moves forward, with a jump or a stray time now and then
  function automatic req_t random_req();
    req_t r;
    int   pick;
    pick = $urandom_range(99);
    if ($urandom_range(19) == 0) now_ms = $urandom;
    else now_ms += $urandom_range(400);
    r.cmd = pick < 15 ? CMD_ACTIVITY : pick < 30 ? CMD_FIRST_KEY :
            pick < 72 ? CMD_SELECT : CMD_COMPLETE;
    r.t_ms = now_ms;
    if (r.cmd == CMD_FIRST_KEY) begin
      case ($urandom_range(3))
        0:       r.t_ms = '1;
        1:       r.t_ms = $urandom;
        default: r.t_ms = $urandom_range(2500);
      endcase
    end else if ($urandom_range(9) == 0) begin
      r.t_ms = $urandom;
    end
    r.rx         = ($urandom_range(3) == 0);
    r.fdx        = 1'($urandom_range(1));
    r.rule_index = ($urandom_range(9) < 8) ? RULE_IDX_W'($urandom_range(NUM_RULES - 1)) :
                                             RULE_IDX_W'($urandom_range(7));
    return r;
  endfunction

  task automatic offer(req_t r);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {1'b0, r};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    s_tvalid = 1'b0;
    wait (outstanding == 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // reset settings: all rules zero, due once activity is seen
    offer(mk(CMD_SELECT, 32'd0, 1'b0, 1'b0, 3'd0));
    offer(mk(CMD_ACTIVITY, 32'd0, 1'b0, 1'b0, 3'd0));
    offer(mk(CMD_SELECT, 32'd0, 1'b0, 1'b1, 3'd0));
    offer(mk(CMD_COMPLETE, 32'd5, 1'b0, 1'b0, 3'd0));
    settle();

    write_reg(REG_RULE0,                  rule_word(32'd100, 8'd5, 1'b0, 1'b0));
    write_reg(REG_RULE0 + CFG_IDX_W'(1), rule_word(32'd0, 8'd200, 1'b1, 1'b0));
    write_reg(REG_RULE0 + CFG_IDX_W'(2), rule_word('1, '1, 1'b0, 1'b1));
    write_reg(REG_RULE0 + CFG_IDX_W'(3), rule_word(32'd50, 8'd5, 1'b0, 1'b1));
    write_reg(CFG_IDX_W'(REG_COUNT), '1);
    write_reg(REG_LAST, '1);

    offer(mk(CMD_SELECT, 32'd0, 1'b0, 1'b0, 3'd0));
    offer(mk(CMD_SELECT, 32'd1000, 1'b1, 1'b0, 3'd0));
    offer(mk(CMD_SELECT, 32'd1000, 1'b1, 1'b1, 3'd0));
    offer(mk(CMD_FIRST_KEY, 32'd0, 1'b0, 1'b0, 3'd0));
    offer(mk(CMD_SELECT, 32'd1000, 1'b0, 1'b0, 3'd0));
    offer(mk(CMD_COMPLETE, 32'd1000, 1'b0, 1'b0, 3'd1));
    offer(mk(CMD_SELECT, 32'd1020, 1'b0, 1'b0, 3'd0));
    offer(mk(CMD_ACTIVITY, '1, 1'b1, 1'b1, 3'd7));
    // rules 0 and 3 tie on priority
    offer(mk(CMD_SELECT, 32'd1100, 1'b0, 1'b0, 3'd0));
    offer(mk(CMD_COMPLETE, 32'd0, 1'b0, 1'b0, 3'd7));
    offer(mk(CMD_COMPLETE, 32'd0, 1'b0, 1'b0, 3'd4));
    offer(mk(CMD_SELECT, '1, 1'b0, 1'b0, 3'd0));
    offer(mk(CMD_COMPLETE, 32'hFFFF_FFF0, 1'b0, 1'b0, 3'd2));
    offer(mk(CMD_ACTIVITY, 32'd0, 1'b0, 1'b0, 3'd0));
    // elapsed time wraps past zero
    offer(mk(CMD_SELECT, 32'h0000_0040, 1'b0, 1'b0, 3'd0));
    offer(mk(CMD_SELECT, 32'h0000_0060, 1'b0, 1'b0, 3'd0));
    offer(mk(CMD_FIRST_KEY, '1, 1'b0, 1'b0, 3'd0));
    offer(mk(CMD_COMPLETE, 32'd7, 1'b0, 1'b0, 3'd3));
    offer(mk(CMD_SELECT, 32'd100, 1'b0, 1'b1, 3'd0));
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin send_idle = 0;  stall_pct = 0;  end
        1: begin send_idle = 81; stall_pct = 0;  end
        2: begin send_idle = 0;  stall_pct = 81; end
        default: begin send_idle = 10; stall_pct = 10; end
      endcase
      for (int i = 0; i < NUM_RULES; i++) begin
        case (phase)
          1:       write_reg(REG_RULE0 + CFG_IDX_W'(i), '1);
          2:       write_reg(REG_RULE0 + CFG_IDX_W'(i), '0);
          default: write_reg(REG_RULE0 + CFG_IDX_W'(i), random_rule());
        endcase
      end
      write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, 2**CFG_IDX_W - 1)),
                CFG_DATA_W'({$urandom, $urandom}));
      now_ms = $urandom;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (phase % 4 == 0 && k == 60) -> holdoff_go;
        if (phase == 5 && k == 120) settle();
        offer(random_req());
      end
      settle();
    end

    $display("covered %0d requests over %0d idling phases and fixed cases", results_seen,
             PHASES);
    $display("%0d selects reported a due rule", hits);
    if (errors == 0) begin
      $display("station_id_rule_scheduler_tb OK");
    end else begin
      $display("station_id_rule_scheduler_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: station_id_rule_scheduler.f
hw/rtl/sirs_pkg.sv
hw/rtl/sirs_rule_mem.sv
hw/rtl/sirs_cfg_regs.sv
hw/rtl/station_id_rule_scheduler.sv
dv/station_id_rule_scheduler_chk.sv
dv/station_id_rule_scheduler_tb.sv
